FILE: rtl/esmt_pkg.sv
// Shared types and constants for the event subscription match table.
// No dependencies; used by the top level and the testbench.
package esmt_pkg;

  localparam int SLOTS        = 16;
  localparam int OBJECT_LIMIT = 16;

  localparam int AO_ID_W  = 8;
  localparam int TYPE_W   = 32;
  localparam int MODULE_W = 32;
  localparam int HANDLE_W = 16;
  localparam int TARGET_W = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Slot index, slot count and stored owner widths.
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int OWNER_W = (OBJECT_LIMIT > 1) ? $clog2(OBJECT_LIMIT) : 1;

  localparam logic [AO_ID_W:0] ID_LIMIT = (AO_ID_W + 1)'(OBJECT_LIMIT);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOTS);

  // Commands.
  localparam logic [CMD_W-1:0] CMD_SUBSCRIBE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUBLISH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAILED  = 2'd3;

  // One subscription as stored in the slot RAM.
  typedef struct packed {
    logic [OWNER_W-1:0]  owner;
    logic [TYPE_W-1:0]   ev_type;
    logic [MODULE_W-1:0] module_word;
    logic [HANDLE_W-1:0] handle;
    logic [TARGET_W-1:0] target;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: rtl/esmt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module esmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/event_subscription_match_table.sv
// Event subscription match table: top level with the command sequencer.
// Depends on esmt_pkg and esmt_ram (slot storage).
// Subscribe, clear and rejected commands: one registered result in the cycle after
//   accept; busy stays low, so the next transaction may start in the next cycle.
// Publish: one slot RAM read per cycle scans every slot in index order; a delivery
//   comes out for each match, then the final status; busy stays high until the
//   final status appears, so no new command is taken meanwhile. Results cannot be stalled.
// Reset empties the table (used count to zero); RAM contents are not cleared.
module event_subscription_match_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [esmt_pkg::CMD_W-1:0]     cmd_i,
  input  logic [esmt_pkg::AO_ID_W-1:0]   ao_id_i,
  input  logic [esmt_pkg::TYPE_W-1:0]    event_type_i,
  input  logic [esmt_pkg::MODULE_W-1:0]  module_req_i,
  input  logic [esmt_pkg::HANDLE_W-1:0]  event_handle_i,
  input  logic [esmt_pkg::TARGET_W-1:0]  post_target_i,
  output logic                           res_valid_o,
  output logic [esmt_pkg::STATUS_W-1:0]  status_o,
  output logic                           is_delivery_o,
  output logic [esmt_pkg::MODULE_W-1:0]  out_module_o,
  output logic [esmt_pkg::HANDLE_W-1:0]  out_handle_o,
  output logic [esmt_pkg::TARGET_W-1:0]  out_target_o,
  output logic                           last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state_q, state_d;

  // Slots only become free through a clear, so valid slots are always the
  // prefix below used_q: the first free slot is used_q itself.
  logic [esmt_pkg::CNT_W-1:0] used_q, used_d;
  // During a scan, the index of the next slot to read.
  logic [esmt_pkg::CNT_W-1:0] scan_q, scan_d;
  logic                       matched_q, matched_d;

  logic [esmt_pkg::OWNER_W-1:0] id_q, id_d;
  logic [esmt_pkg::TYPE_W-1:0]  type_q, type_d;

  // Result registers.
  logic                           res_valid_q, res_valid_d;
  logic [esmt_pkg::STATUS_W-1:0]  status_q, status_d;
  logic                           deliv_q, deliv_d;
  logic [esmt_pkg::MODULE_W-1:0]  module_q, module_d;
  logic [esmt_pkg::HANDLE_W-1:0]  handle_q, handle_d;
  logic [esmt_pkg::TARGET_W-1:0]  target_q, target_d;
  logic                           last_q, last_d;

  // Slot RAM ports.
  logic                         ram_we;
  logic [esmt_pkg::IDX_W-1:0]   ram_raddr;
  esmt_pkg::slot_t              ram_wdata;
  esmt_pkg::slot_t              ram_rdata;
  logic [esmt_pkg::SLOT_W-1:0]  ram_rdata_raw;

  logic accept;
  logic id_ok;
  logic null_arg;
  logic full;
  logic slot_live;
  logic hit;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign id_ok    = ({1'b0, ao_id_i} < esmt_pkg::ID_LIMIT);
  assign null_arg = (event_handle_i == '0) || (post_target_i == '0);
  assign full     = (used_q >= esmt_pkg::SLOT_CNT);

  assign ram_wdata.owner       = ao_id_i[esmt_pkg::OWNER_W-1:0];
  assign ram_wdata.ev_type     = event_type_i;
  assign ram_wdata.module_word = module_req_i;
  assign ram_wdata.handle      = event_handle_i;
  assign ram_wdata.target      = post_target_i;
  assign ram_rdata             = esmt_pkg::slot_t'(ram_rdata_raw);

  // Read slot 0 while idle so a publish finds it ready in its first scan
  // cycle; park the address once every slot has been read.
  assign ram_raddr = (state_q == ST_SCAN && scan_q != esmt_pkg::SLOT_CNT) ?
                     scan_q[esmt_pkg::IDX_W-1:0] : '0;

  // The pending read was slot scan_q-1; it is valid when below used_q.
  assign slot_live = (state_q == ST_SCAN) && (scan_q <= used_q);
  assign hit       = slot_live && (ram_rdata.owner == id_q) &&
                     (ram_rdata.ev_type == type_q);

  esmt_ram #(
    .WIDTH (esmt_pkg::SLOT_W),
    .DEPTH (esmt_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (used_q[esmt_pkg::IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    scan_d      = scan_q;
    matched_d   = matched_q;
    id_d        = id_q;
    type_d      = type_q;
    ram_we      = 1'b0;
    // Default: a status-only final result, not presented.
    res_valid_d = 1'b0;
    status_d    = esmt_pkg::STATUS_OK;
    deliv_d     = 1'b0;
    module_d    = '0;
    handle_d    = '0;
    target_d    = '0;
    last_d      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          priority if (cmd_i == esmt_pkg::CMD_SUBSCRIBE) begin
            priority if (!id_ok) begin
              status_d = esmt_pkg::STATUS_INVALID;
            end else if (null_arg) begin
              status_d = esmt_pkg::STATUS_NULL;
            end else if (full) begin
              status_d = esmt_pkg::STATUS_FAILED;
            end else begin
              ram_we = 1'b1;
              used_d = used_q + 1'b1;
            end
          end else if (cmd_i == esmt_pkg::CMD_PUBLISH) begin
            if (id_ok) begin
              // Hold the result back and start the scan.
              res_valid_d = 1'b0;
              state_d     = ST_SCAN;
              scan_d      = esmt_pkg::CNT_W'(1);
              matched_d   = 1'b0;
              id_d        = ao_id_i[esmt_pkg::OWNER_W-1:0];
              type_d      = event_type_i;
            end else begin
              status_d = esmt_pkg::STATUS_INVALID;
            end
          end else if (cmd_i == esmt_pkg::CMD_CLEAR) begin
            used_d = '0;
          end else begin
            status_d = esmt_pkg::STATUS_INVALID;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_valid_d = 1'b1;
          deliv_d     = 1'b1;
          last_d      = 1'b0;
          module_d    = ram_rdata.module_word;
          handle_d    = ram_rdata.handle;
          target_d    = ram_rdata.target;
          matched_d   = 1'b1;
        end
        if (scan_q == esmt_pkg::SLOT_CNT) begin
          state_d = ST_FINAL;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_FINAL: begin
        res_valid_d = 1'b1;
        status_d    = matched_q ? esmt_pkg::STATUS_OK : esmt_pkg::STATUS_FAILED;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      scan_q      <= '0;
      matched_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      scan_q      <= scan_d;
      matched_q   <= matched_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    type_q   <= type_d;
    status_q <= status_d;
    deliv_q  <= deliv_d;
    module_q <= module_d;
    handle_q <= handle_d;
    target_q <= target_d;
    last_q   <= last_d;
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = status_q;
  assign is_delivery_o = deliv_q;
  assign out_module_o  = module_q;
  assign out_handle_o  = handle_q;
  assign out_target_o  = target_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  // Never count more subscriptions than slots.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= esmt_pkg::SLOT_CNT)
    else $error("used count exceeds slot count");

  // A publish with a valid id occupies the sequencer.
  a_publish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == esmt_pkg::CMD_PUBLISH && id_ok) |=> busy)
    else $error("publish did not start a scan");

  // Deliveries only come out while the scan is still in progress.
  a_deliv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && is_delivery_o) |-> (busy && !last_o))
    else $error("delivery outside a scan");

  // Leaving a scan coincides with its final status transaction.
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (res_valid_o && last_o && !is_delivery_o))
    else $error("scan ended without final status");
`endif

endmodule

FILE: dv/event_subscription_match_table_tb.sv
// Self-checking testbench for the event subscription match table.
// Depends on esmt_pkg and the event_subscription_match_table RTL; predicts every
// result of each accepted command and checks it field by field as it arrives.
module event_subscription_match_table_tb;
  import esmt_pkg::*;

  // The package names only the three real commands; the fourth code is reserved.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  // A publish holds busy until its final status appears.
  localparam int DRAIN_CYCLES = SLOTS + 4;
  localparam int RANDOM_ITEMS = 204;
  localparam int POOL_N       = 4;

  // One result as it should appear on the result ports.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                deliv;
    logic [MODULE_W-1:0] module_word;
    logic [HANDLE_W-1:0] handle;
    logic [TARGET_W-1:0] target;
    logic                last;
  } response_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i;
  logic [AO_ID_W-1:0]  ao_id_i;
  logic [TYPE_W-1:0]   event_type_i;
  logic [MODULE_W-1:0] module_req_i;
  logic [HANDLE_W-1:0] event_handle_i;
  logic [TARGET_W-1:0] post_target_i;
  logic                res_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic                is_delivery_o;
  logic [MODULE_W-1:0] out_module_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic [TARGET_W-1:0] out_target_o;
  logic                last_o;

  // Shadow copy of the subscription table.
  logic                tbl_valid  [SLOTS];
  logic [AO_ID_W-1:0]  tbl_owner  [SLOTS];
  logic [TYPE_W-1:0]   tbl_type   [SLOTS];
  logic [MODULE_W-1:0] tbl_module [SLOTS];
  logic [HANDLE_W-1:0] tbl_handle [SLOTS];
  logic [TARGET_W-1:0] tbl_target [SLOTS];
  int                  tbl_used;

  // Results predicted but not yet seen, oldest first.
  response_t awaited_results[$];
  response_t head_rsp;

  // Small pools of ids and types so that publishes actually find subscriptions.
  logic [AO_ID_W-1:0] id_pool   [POOL_N];
  logic [TYPE_W-1:0]  type_pool [POOL_N];

  // Suppress random idling while set.
  bit steady;

  int fail_count;
  int n_sub, n_pub, n_clr, n_bad, n_full, n_results, n_deliv;

  event_subscription_match_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .ao_id_i        (ao_id_i),
    .event_type_i   (event_type_i),
    .module_req_i   (module_req_i),
    .event_handle_i (event_handle_i),
    .post_target_i  (post_target_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .is_delivery_o  (is_delivery_o),
    .out_module_o   (out_module_o),
    .out_handle_o   (out_handle_o),
    .out_target_o   (out_target_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run; a hang in the handshake or a lost result ends here.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // Work out the results of one accepted transaction and update the shadow table.
  task automatic resolve_command(input logic [CMD_W-1:0] cmd, input logic [AO_ID_W-1:0] id,
                                 input logic [TYPE_W-1:0] ev, input logic [MODULE_W-1:0] mw,
                                 input logic [HANDLE_W-1:0] hd,
                                 input logic [TARGET_W-1:0] tg);
    response_t rsp;
    bit        claimed;
    bit        hit;
    rsp      = '0;
    rsp.last = 1'b1;
    claimed  = 1'b0;
    hit      = 1'b0;
    case (cmd)
      CMD_SUBSCRIBE: begin
        n_sub++;
        // Check order matters: a bad id wins over null operands, both over a full table.
        if (id >= OBJECT_LIMIT) begin
          rsp.status = STATUS_INVALID;
        end else if (hd == '0 || tg == '0) begin
          rsp.status = STATUS_NULL;
        end else if (tbl_used >= SLOTS) begin
          rsp.status = STATUS_FAILED;
          n_full++;
        end else begin
          // Take the lowest free slot.
          for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i] && !claimed) begin
              tbl_valid[i]  = 1'b1;
              tbl_owner[i]  = id;
              tbl_type[i]   = ev;
              tbl_module[i] = mw;
              tbl_handle[i] = hd;
              tbl_target[i] = tg;
              claimed       = 1'b1;
            end
          end
          tbl_used++;
          rsp.status = STATUS_OK;
        end
        awaited_results.push_back(rsp);
      end
      CMD_PUBLISH: begin
        n_pub++;
        if (id >= OBJECT_LIMIT) begin
          rsp.status = STATUS_INVALID;
        end else begin
          // Deliver every matching slot in index order, then the final status.
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_owner[i] == id && tbl_type[i] == ev) begin
              awaited_results.push_back('{status: STATUS_OK, deliv: 1'b1,
                                          module_word: tbl_module[i],
                                          handle: tbl_handle[i], target: tbl_target[i],
                                          last: 1'b0});
              hit = 1'b1;
            end
          end
          rsp.status = hit ? STATUS_OK : STATUS_FAILED;
        end
        awaited_results.push_back(rsp);
      end
      CMD_CLEAR: begin
        n_clr++;
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_used   = 0;
        rsp.status = STATUS_OK;
        awaited_results.push_back(rsp);
      end
      default: begin
        n_bad++;
        rsp.status = STATUS_INVALID;
        awaited_results.push_back(rsp);
      end
    endcase
  endtask

  // Drive one transaction and hold it until accepted. Enter and leave at a falling edge
  // with start still high, so back-to-back transactions need no extra assignment.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [AO_ID_W-1:0] id,
                          input logic [TYPE_W-1:0] ev, input logic [MODULE_W-1:0] mw,
                          input logic [HANDLE_W-1:0] hd, input logic [TARGET_W-1:0] tg);
    // Idle first now and then: drop start and put junk on the fields meanwhile.
    if (!steady && $urandom_range(99) < 9) begin
      start          <= 1'b0;
      cmd_i          <= CMD_W'($urandom);
      ao_id_i        <= AO_ID_W'($urandom);
      event_type_i   <= $urandom;
      module_req_i   <= $urandom;
      event_handle_i <= HANDLE_W'($urandom);
      post_target_i  <= TARGET_W'($urandom);
      do @(negedge clk_i); while ($urandom_range(99) < 9);
    end
    start          <= 1'b1;
    cmd_i          <= cmd;
    ao_id_i        <= id;
    event_type_i   <= ev;
    module_req_i   <= mw;
    event_handle_i <= hd;
    post_target_i  <= tg;
    // Busy is read as it stood before the edge; hold while the block is busy.
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    resolve_command(cmd, id, ev, mw, hd, tg);
    @(negedge clk_i);
  endtask

  // Drop start once no further transaction follows.
  task automatic release_bus();
    start <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < POOL_N; i++) begin
      id_pool[i]   = AO_ID_W'($urandom_range(OBJECT_LIMIT - 1));
      type_pool[i] = $urandom;
    end
  endtask

  function automatic logic [AO_ID_W-1:0] pick_id();
    return ($urandom_range(99) < 88) ? id_pool[$urandom_range(POOL_N - 1)]
                                     : AO_ID_W'($urandom);
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    return ($urandom_range(99) < 88) ? type_pool[$urandom_range(POOL_N - 1)] : $urandom;
  endfunction

  // Extremes, every command and every rejection path but a full table, in a known order.
  task automatic test_directed_commands();
    send_cmd(CMD_CLEAR, 8'h00, '0, '0, '0, '0);
    send_cmd(CMD_RESERVED, 8'h03, $urandom, $urandom, 16'h1234, 8'h56);
    // Publish on an empty table, then with out-of-range ids.
    send_cmd(CMD_PUBLISH, 8'd0, 32'h0, '0, '0, '0);
    send_cmd(CMD_PUBLISH, 8'd16, 32'h0, '0, '0, '0);
    send_cmd(CMD_PUBLISH, 8'hff, '1, '1, '1, '1);
    // Subscribe rejections: a bad id beats null operands.
    send_cmd(CMD_SUBSCRIBE, 8'd16, 32'h1, 32'h1, 16'h0, 8'h0);
    send_cmd(CMD_SUBSCRIBE, 8'hff, '1, '1, '1, '1);
    send_cmd(CMD_SUBSCRIBE, 8'd0, 32'h0, 32'h0, 16'h0, 8'h05);
    send_cmd(CMD_SUBSCRIBE, 8'd0, 32'h0, 32'h0, 16'h0005, 8'h0);
    // Accepted subscriptions at both ends of every field.
    send_cmd(CMD_SUBSCRIBE, 8'd0, 32'h0, 32'h0, 16'h0001, 8'h01);
    send_cmd(CMD_SUBSCRIBE, 8'd15, '1, '1, '1, '1);
    send_cmd(CMD_SUBSCRIBE, 8'd15, '1, 32'h5a5a_a5a5, 16'h8000, 8'h80);
    // Two matches, a type miss, one match, another type miss.
    send_cmd(CMD_PUBLISH, 8'd15, '1, '0, '0, '0);
    send_cmd(CMD_PUBLISH, 8'd15, 32'h0, '1, '1, '1);
    send_cmd(CMD_PUBLISH, 8'd0, 32'h0, '0, '0, '0);
    send_cmd(CMD_PUBLISH, 8'd0, '1, '0, '0, '0);
    // Owner mismatch with a matching type.
    send_cmd(CMD_PUBLISH, 8'd1, 32'h0, '0, '0, '0);
    // Clear empties everything; slot 0 is reused afterwards.
    send_cmd(CMD_CLEAR, '1, '1, '1, '1, '1);
    send_cmd(CMD_PUBLISH, 8'd15, '1, '0, '0, '0);
    send_cmd(CMD_SUBSCRIBE, 8'd7, 32'hdead_beef, 32'h0123_4567, 16'h7fff, 8'h7f);
    send_cmd(CMD_PUBLISH, 8'd7, 32'hdead_beef, '0, '0, '0);
    send_cmd(CMD_RESERVED, 8'd7, 32'hdead_beef, '0, '0, '0);
  endtask

  // Mostly subscribe and publish on pooled ids and types, with some noise.
  task automatic test_random_traffic();
    int r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) refresh_pools();
      // Run one long stretch without any idling.
      steady = (n >= 90 && n < 150);
      r = $urandom_range(99);
      if (r < 3) begin
        send_cmd(CMD_CLEAR, AO_ID_W'($urandom), $urandom, $urandom,
                 HANDLE_W'($urandom), TARGET_W'($urandom));
      end else if (r < 6) begin
        send_cmd(CMD_RESERVED, pick_id(), pick_type(), $urandom,
                 HANDLE_W'($urandom), TARGET_W'($urandom));
      end else if (r < 50) begin
        send_cmd(CMD_SUBSCRIBE, pick_id(), pick_type(), $urandom,
                 ($urandom_range(99) < 6) ? '0 : HANDLE_W'($urandom),
                 ($urandom_range(99) < 6) ? '0 : TARGET_W'($urandom));
      end else begin
        send_cmd(CMD_PUBLISH, pick_id(), pick_type(), $urandom,
                 HANDLE_W'($urandom), TARGET_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Fill the table with one owner and type, overflow it, then publish the full set.
  task automatic test_table_overflow();
    logic [AO_ID_W-1:0] id;
    logic [TYPE_W-1:0]  ev;
    repeat (2) begin
      refresh_pools();
      id = id_pool[0];
      ev = type_pool[0];
      send_cmd(CMD_CLEAR, '0, '0, '0, '0, '0);
      repeat (SLOTS + 2) begin
        send_cmd(CMD_SUBSCRIBE, id, ev, $urandom, HANDLE_W'($urandom_range(1, 16'hffff)),
                 TARGET_W'($urandom_range(1, 8'hff)));
      end
      send_cmd(CMD_PUBLISH, id, ev, $urandom, HANDLE_W'($urandom), TARGET_W'($urandom));
      send_cmd(CMD_PUBLISH, id, ~ev, $urandom, HANDLE_W'($urandom), TARGET_W'($urandom));
      send_cmd(CMD_PUBLISH, id, ev, $urandom, HANDLE_W'($urandom), TARGET_W'($urandom));
    end
  endtask

  // Compare each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        $error("result with no transaction pending: status %0d, delivery %0b",
               status_o, is_delivery_o);
        fail_count++;
      end else begin
        head_rsp = awaited_results.pop_front();
        if (head_rsp.deliv) n_deliv++;
        if (status_o !== head_rsp.status) begin
          $error("status mismatch: expected %0d, got %0d", head_rsp.status, status_o);
          fail_count++;
        end
        if (is_delivery_o !== head_rsp.deliv) begin
          $error("is_delivery mismatch: expected %0b, got %0b", head_rsp.deliv,
                 is_delivery_o);
          fail_count++;
        end
        if (out_module_o !== head_rsp.module_word) begin
          $error("out_module mismatch: expected %h, got %h", head_rsp.module_word,
                 out_module_o);
          fail_count++;
        end
        if (out_handle_o !== head_rsp.handle) begin
          $error("out_handle mismatch: expected %h, got %h", head_rsp.handle, out_handle_o);
          fail_count++;
        end
        if (out_target_o !== head_rsp.target) begin
          $error("out_target mismatch: expected %h, got %h", head_rsp.target, out_target_o);
          fail_count++;
        end
        if (last_o !== head_rsp.last) begin
          $error("last mismatch: expected %0b, got %0b", head_rsp.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // Hold every input at a known value through reset.
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_i          = '0;
    ao_id_i        = '0;
    event_type_i   = '0;
    module_req_i   = '0;
    event_handle_i = '0;
    post_target_i  = '0;
    steady         = 1'b0;
    fail_count     = 0;
    tbl_used       = 0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_commands();
    test_random_traffic();
    test_table_overflow();
    release_bus();

    // Wait out every predicted result, then a little longer for strays.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d subscribe, %0d publish, %0d clear and %0d reserved commands.",
             n_sub, n_pub, n_clr, n_bad);
    $display("Checked %0d results with %0d deliveries; %0d subscribes met a full table.",
             n_results, n_deliv, n_full);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
